FILE: hdl/tapc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapc_pkg
// Shared types and constants of the attribute policy checker.
// ----------------------------------------------------------------------------
package tapc_pkg;

	localparam int KIND_MAX  = 15;
	localparam int HDR_BYTES = 4;

	localparam logic [4:0] K_UNSPEC = 5'd0;
	localparam logic [4:0] K_STRING = 5'd5;
	localparam logic [4:0] K_FLAG   = 5'd6;
	localparam logic [4:0] K_NESTED = 5'd8;
	localparam logic [4:0] K_COMPAT = 5'd9;
	localparam logic [4:0] K_NULSTR = 5'd10;
	localparam logic [4:0] K_BINARY = 5'd11;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SKIP  = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [1:0] CFG_MAX_TYPE     = 2'd0;
	localparam logic [1:0] CFG_CHECK_ENABLE = 2'd1;

	typedef struct packed {
		logic        last;
		logic        done;
		logic [1:0]  status;
		logic [15:0] offset;
		logic [13:0] atype;
	} res_t;

	// Minimum payload length of the fixed-size kinds.
	function automatic logic [3:0] kind_min(input logic [3:0] k);
		logic [3:0] m;
		unique case (k)
			4'd1, 4'd12:        m = 4'd1;
			4'd2, 4'd13:        m = 4'd2;
			4'd3, 4'd8, 4'd14:  m = 4'd4;
			4'd4, 4'd7, 4'd15:  m = 4'd8;
			default:            m = 4'd0;
		endcase
		return m;
	endfunction

endpackage

FILE: hdl/tapc_policy_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapc_policy_mem
// Policy table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tapc_policy_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [20:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [20:0]   rdata
);

	logic [20:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/tapc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapc_parser
// Attribute walk state, payload tracking and policy verdict for one byte.
// ----------------------------------------------------------------------------
module tapc_parser import tapc_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic [7:0]  byte_in,
	input  logic        end_in,
	input  logic [20:0] entry,
	input  logic [5:0]  max_type,
	input  logic        check_en,
	output res_t        res0,
	output res_t        res1,
	output logic [1:0]  nres,
	output logic [13:0] fwd_type,
	output logic        fwd_hdr3
);

	typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_PAD, PH_IDLE} phase_t;

	phase_t      phase_q, phase_n, phase_pre;
	logic [15:0] off_q, off_n, pos_q, pos_n, len_q, len_n, inner_q, inner_n;
	logic [13:0] type_q, type_n;
	logic        nul_q, nul_n;
	logic [7:0]  prev_q, prev_n;
	logic [1:0]  fail_q, fail_n;

	logic        oob, complete;
	logic [20:0] e;
	logic [4:0]  kind;
	logic [15:0] plen, alen, idx, hdr_off, pos_inc;
	logic [17:0] a, nl, a4, a4i;
	logic [16:0] sn;
	logic [1:0]  st;

	assign oob  = {1'b0, type_q} >= 15'(ENTRIES);
	assign e    = oob ? 21'd0 : entry;
	assign kind = e[20:16];
	assign plen = e[15:0];
	assign a    = (18'(plen) + 18'd3) & ~18'd3;
	assign a4   = a + 18'(HDR_BYTES);
	assign idx  = pos_q - 16'(HDR_BYTES);

	// Verdict of the attribute whose last byte is this one.
	always_comb begin
		logic [15:0] vlen;
		logic [17:0] vnl;
		vlen = len_n - 16'(HDR_BYTES);
		vnl  = (plen != 16'd0 && 18'(plen) + 18'd1 < 18'(vlen)) ?
			18'(plen) + 18'd1 : 18'(vlen);
		a4i  = a4 + 18'(inner_n);
		sn   = 17'(vlen) - ((prev_n == 8'd0) ? 17'd1 : 17'd0);
		st   = ST_OK;
		if (type_n > {8'd0, max_type} || oob) begin
			st = ST_SKIP;
		end else if (!check_en) begin
			st = ST_OK;
		end else if (kind > 5'(KIND_MAX)) begin
			st = ST_BAD;
		end else if (kind == K_FLAG) begin
			st = (vlen != 16'd0) ? ST_BAD : ST_OK;
		end else if (kind == K_NULSTR) begin
			st = (vnl == 18'd0 || !nul_n) ? ST_BAD : ST_OK;
		end else if (kind == K_STRING) begin
			if (vlen == 16'd0) st = ST_BAD;
			else if (plen != 16'd0 && sn > 17'(plen)) st = ST_BAD;
		end else if (kind == K_BINARY) begin
			st = (plen != 16'd0 && vlen > plen) ? ST_BAD : ST_OK;
		end else if (kind == K_COMPAT) begin
			if (vlen < plen) st = ST_BAD;
			else if (18'(vlen) < a) st = ST_OK;
			else if (18'(vlen) < a4 || 18'(vlen) < a4i) st = ST_BAD;
		end else if (kind == K_NESTED && vlen == 16'd0) begin
			st = ST_OK;
		end else if (plen != 16'd0) begin
			st = (vlen < plen) ? ST_BAD : ST_OK;
		end else if (kind != K_UNSPEC && vlen < 16'(kind_min(kind[3:0]))) begin
			st = ST_BAD;
		end
	end

	assign nl = (plen != 16'd0 && 18'(plen) + 18'd1 < 18'(len_q - 16'(HDR_BYTES))) ?
		18'(plen) + 18'd1 : 18'(len_q - 16'(HDR_BYTES));
	assign pos_inc = pos_q + 16'd1;

	always_comb begin
		phase_pre = phase_q;
		pos_n     = pos_q;
		len_n     = len_q;
		type_n    = type_q;
		nul_n     = nul_q;
		prev_n    = prev_q;
		inner_n   = inner_q;
		complete  = 1'b0;
		if (valid) begin
			unique case (phase_q)
				PH_HEADER: begin
					unique case (pos_q[1:0])
						2'd0: len_n = {8'd0, byte_in};
						2'd1: len_n = {byte_in, len_q[7:0]};
						2'd2: type_n = {6'd0, byte_in};
						default: type_n = {byte_in[5:0], type_q[7:0]};
					endcase
					pos_n = pos_inc;
					if (pos_inc >= 16'(HDR_BYTES)) begin
						nul_n   = 1'b0;
						inner_n = 16'd0;
						prev_n  = 8'd0;
						if (len_n < 16'(HDR_BYTES)) phase_pre = PH_IDLE;
						else if (len_n == 16'(HDR_BYTES)) complete = 1'b1;
						else phase_pre = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (byte_in == 8'd0 && 18'(idx) < nl) nul_n = 1'b1;
					if (18'(idx) == a) inner_n = {8'd0, byte_in};
					if (18'(idx) == a + 18'd1) inner_n = inner_q | {byte_in, 8'd0};
					prev_n = byte_in;
					pos_n  = pos_inc;
					if (pos_inc >= len_q) complete = 1'b1;
				end
				PH_PAD: begin
					pos_n = pos_q - 16'd1;
					if (pos_n == 16'd0) phase_pre = PH_HEADER;
				end
				default: begin
				end
			endcase
		end
	end

	assign hdr_off = off_q + 16'd1 - pos_n;

	always_comb begin
		phase_n  = phase_pre;
		fail_n   = fail_q;
		off_n    = off_q;
		res0     = '0;
		res1     = '0;
		nres     = 2'd0;
		fwd_type = type_n;
		fwd_hdr3 = (phase_pre == PH_HEADER) && (pos_n == 16'd3);
		if (valid) begin
			if (complete) begin
				res0 = '{last: 1'b0, done: 1'b0, status: st, offset: hdr_off,
					atype: type_n};
				nres = 2'd1;
				if (st == ST_BAD) begin
					fail_n  = ST_BAD;
					phase_n = PH_IDLE;
				end else begin
					phase_n = ((~len_n[1:0] + 2'd1) != 2'd0) ? PH_PAD : PH_HEADER;
				end
				fwd_hdr3 = 1'b0;
				if ((~len_n[1:0] + 2'd1) == 2'd3 && phase_n == PH_PAD) fwd_hdr3 = 1'b0;
			end
			off_n = off_q + 16'd1;
			if (end_in) begin
				fwd_type = 14'd0;
				fwd_hdr3 = 1'b0;
				if (phase_n == PH_PAYLOAD) begin
					res0 = '{last: 1'b0, done: 1'b0, status: ST_RANGE, offset: hdr_off,
						atype: type_n};
					res1 = '{last: 1'b1, done: 1'b1, status: ST_RANGE, offset: 16'd0,
						atype: 14'd0};
					nres = 2'd2;
				end else if (complete) begin
					res1 = '{last: 1'b1, done: 1'b1, status: fail_n, offset: 16'd0,
						atype: 14'd0};
					nres = 2'd2;
				end else begin
					res0 = '{last: 1'b1, done: 1'b1, status: fail_n, offset: 16'd0,
						atype: 14'd0};
					nres = 2'd1;
				end
			end else if (complete) begin
				res0.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			off_q   <= '0;
			pos_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			nul_q   <= 1'b0;
			prev_q  <= '0;
			inner_q <= '0;
			fail_q  <= '0;
		end else if (valid) begin
			if (end_in) begin
				phase_q <= PH_HEADER;
				off_q   <= '0;
				pos_q   <= '0;
				len_q   <= '0;
				type_q  <= '0;
				nul_q   <= 1'b0;
				prev_q  <= '0;
				inner_q <= '0;
				fail_q  <= '0;
			end else begin
				phase_q <= phase_n;
				off_q   <= off_n;
				pos_q   <= complete ? {14'd0, ~len_n[1:0] + 2'd1} : pos_n;
				len_q   <= len_n;
				type_q  <= type_n;
				nul_q   <= nul_n;
				prev_q  <= prev_n;
				inner_q <= inner_n;
				fail_q  <= fail_n;
			end
		end
	end

endmodule

FILE: hdl/tapc_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapc_result_fifo
// Eight-deep result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
module tapc_result_fifo import tapc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  res_t       res0,
	input  res_t       res1,
	input  logic [1:0] nres,
	input  logic       pop,
	output res_t       head,
	output logic [3:0] count
);

	res_t       buf_q [0:7];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;

	assign head  = buf_q[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (nres != 2'd0) buf_q[wp_q] <= res0;
		if (nres == 2'd2) buf_q[wp_q + 3'd1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + {1'b0, nres};
			rp_q  <= rp_q + {2'd0, pop};
			cnt_q <= cnt_q + {2'd0, nres} - {3'd0, pop};
		end
	end

endmodule

FILE: hdl/tlv_attribute_policy_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_attribute_policy_check_unit
// Byte-serial attribute walker that checks each attribute against a policy
// table held in a synchronous memory.
// ----------------------------------------------------------------------------
// Throughput: one beat (stream byte or policy write) per cycle while the
// result queue has room; the policy memory read is the only pipeline step.
// A result reaches the master side through the memory read at the edge that
// accepts its byte and then the queue write.
// Reset: arst_n clears the walk state, the queue and the registers to their
// defaults at once; the policy table is not cleared and must be written.
module tlv_attribute_policy_check_unit import tapc_pkg::*; #(
	parameter int POLICY_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side: tdata from bit 0 up holds data_byte[7:0], policy_slot[13:8],
	// policy_kind[18:14], policy_limit[34:19], zeros above.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,   // mode
	input  logic        s_tlast,   // block_end
	// Master side: tdata from bit 0 up holds attr_type[13:0],
	// attr_offset[29:14], status[31:30].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tuser,   // block_done
	output logic        m_tlast,   // is_last
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	localparam int AW = (POLICY_ENTRIES > 1) ? $clog2(POLICY_ENTRIES) : 1;

	logic        s_acc, byte_acc, pol_we;
	logic [13:0] slot14, raddr14, fwd_type;
	logic        fwd_hdr3;
	logic [20:0] entry;
	logic        bv_s1, end_s1;
	logic [7:0]  byte_s1;
	logic [5:0]  max_type_q;
	logic        check_en_q;
	res_t        res0, res1, head;
	logic [1:0]  nres;
	logic [3:0]  count;
	logic        pop;

	assign cfg_ready = 1'b1;

	// Room is reserved for two results of the byte in flight and two for
	// the new one, so nothing is ever dropped.
	assign s_tready = ({1'b0, count} + {2'd0, bv_s1, 1'b0}) <= 5'd4;
	assign s_acc    = s_tvalid && s_tready;
	assign byte_acc = s_acc && s_tuser;

	assign slot14 = {8'd0, s_tdata[13:8]};
	assign pol_we = s_acc && !s_tuser && ({1'b0, slot14} < 15'(POLICY_ENTRIES));

	// The lookup address follows the type the walker will hold after the
	// byte now in flight; for the last header byte the high type bits come
	// straight from the incoming byte.
	assign raddr14 = fwd_hdr3 ? {s_tdata[5:0], fwd_type[7:0]} : fwd_type;

	tapc_policy_mem #(.DEPTH(POLICY_ENTRIES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (pol_we),
		.waddr (slot14[AW-1:0]),
		.wdata ({s_tdata[18:14], s_tdata[34:19]}),
		.re    (byte_acc),
		.raddr (raddr14[AW-1:0]),
		.rdata (entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_s1      <= 1'b0;
			max_type_q <= 6'd63;
			check_en_q <= 1'b1;
		end else begin
			bv_s1 <= byte_acc;
			if (cfg_valid && cfg_index == CFG_MAX_TYPE) max_type_q <= cfg_data;
			if (cfg_valid && cfg_index == CFG_CHECK_ENABLE) check_en_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc) begin
			byte_s1 <= s_tdata[7:0];
			end_s1  <= s_tlast;
		end
	end

	tapc_parser #(.ENTRIES(POLICY_ENTRIES)) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (bv_s1),
		.byte_in  (byte_s1),
		.end_in   (end_s1),
		.entry    (entry),
		.max_type (max_type_q),
		.check_en (check_en_q),
		.res0     (res0),
		.res1     (res1),
		.nres     (nres),
		.fwd_type (fwd_type),
		.fwd_hdr3 (fwd_hdr3)
	);

	assign pop = m_tvalid && m_tready;

	tapc_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.res0   (res0),
		.res1   (res1),
		.nres   (nres),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	assign m_tvalid = count != 4'd0;
	assign m_tdata  = {head.status, head.offset, head.atype};
	assign m_tuser  = head.done;
	assign m_tlast  = head.last;

	// The queue never holds more than it has slots.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= 4'd8) else $error("result queue overflow");

	// An accepted byte is worked on in the following cycle.
	a_byte_flows: assert property (@(posedge clk) disable iff (!arst_n)
		byte_acc |=> bv_s1) else $error("accepted byte lost");

	// A final block status carries neither type nor offset.
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[29:0] == 30'd0 && m_tlast))
		else $error("malformed block status");

	// No result without a byte in flight.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(nres != 2'd0) |-> bv_s1) else $error("result without byte");

endmodule
